// File: rtl/biq_pkg.sv
// Shared types and constants for the direct-form-I biquad block.
package biq_pkg;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_COEF_B0       = 3'd0,
    REG_COEF_B1       = 3'd1,
    REG_COEF_B2       = 3'd2,
    REG_COEF_A1       = 3'd3,
    REG_COEF_A2       = 3'd4,
    REG_ADC_PATH      = 3'd5,
    REG_FILTER_ENABLE = 3'd6
  } cfg_reg_e;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int COEF_W      = 32;
  localparam int SAMPLE_W    = 16;
  localparam int CODE_W      = 12;

  localparam logic signed [SAMPLE_W-1:0] Q15_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] Q15_MIN = 16'sh8000;

  // Converter codes carry 4 fewer bits than a Q15 sample
  localparam int CODE_SHIFT = 4;

  typedef struct packed {
    logic        [CODE_W-1:0]   adc_code;
    logic signed [SAMPLE_W-1:0] sample_in;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic        [CODE_W-1:0]   dac_code;
  } out_t;

  // Configuration state seen by the datapath
  typedef struct packed {
    logic signed [COEF_W-1:0] coef_b0;
    logic signed [COEF_W-1:0] coef_b1;
    logic signed [COEF_W-1:0] coef_b2;
    logic signed [COEF_W-1:0] coef_a1;
    logic signed [COEF_W-1:0] coef_a2;
    logic                     adc_path;
    logic                     filter_enable;
  } cfg_t;

endpackage

// File: rtl/biq_cfg_regs.sv
// Configuration register file for the biquad block.
module biq_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [biq_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [biq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output biq_pkg::cfg_t                    cfg
);
  import biq_pkg::*;

  // Decode the index and update the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_b0       <= '0;
      cfg.coef_b1       <= '0;
      cfg.coef_b2       <= '0;
      cfg.coef_a1       <= '0;
      cfg.coef_a2       <= '0;
      cfg.adc_path      <= 1'b1;
      cfg.filter_enable <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_COEF_B0:       cfg.coef_b0       <= $signed(cfg_wdata[COEF_W-1:0]);
        REG_COEF_B1:       cfg.coef_b1       <= $signed(cfg_wdata[COEF_W-1:0]);
        REG_COEF_B2:       cfg.coef_b2       <= $signed(cfg_wdata[COEF_W-1:0]);
        REG_COEF_A1:       cfg.coef_a1       <= $signed(cfg_wdata[COEF_W-1:0]);
        REG_COEF_A2:       cfg.coef_a2       <= $signed(cfg_wdata[COEF_W-1:0]);
        REG_ADC_PATH:      cfg.adc_path      <= cfg_wdata[0];
        REG_FILTER_ENABLE: cfg.filter_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/biq_front.sv
// Input conditioning: converter code to Q15, or Q15 sample passed on.
module biq_front #(
  parameter int ADC_MID = 2048
) (
  input  biq_pkg::in_t                         in_data,
  input  logic                                 adc_path,
  output logic signed [biq_pkg::SAMPLE_W-1:0]  x0
);
  import biq_pkg::*;

  // Code minus midpoint, times 16, is held in 18 signed bits
  localparam int EXT_W = CODE_W + CODE_SHIFT + 2;
  localparam logic signed [EXT_W-1:0] ADC_MID_S = EXT_W'(ADC_MID);
  localparam logic signed [EXT_W-1:0] HI_S      = EXT_W'(Q15_MAX);
  localparam logic signed [EXT_W-1:0] LO_S      = EXT_W'(Q15_MIN);

  logic signed [EXT_W-1:0] diff;
  logic signed [EXT_W-1:0] scaled;
  logic signed [SAMPLE_W-1:0] adc_q15;

  // Centre the code and scale it up
  assign diff   = $signed({{(EXT_W-CODE_W){1'b0}}, in_data.adc_code}) - ADC_MID_S;
  assign scaled = diff <<< CODE_SHIFT;

  // Clamp to Q15 and pick the active path
  always_comb begin
    if (scaled > HI_S) begin
      adc_q15 = Q15_MAX;
    end else if (scaled < LO_S) begin
      adc_q15 = Q15_MIN;
    end else begin
      adc_q15 = scaled[SAMPLE_W-1:0];
    end
    x0 = adc_path ? adc_q15 : in_data.sample_in;
  end

endmodule

// File: rtl/biq_core.sv
// Biquad arithmetic: five products, sum, rescale, saturate, DAC code; holds history.
module biq_core #(
  parameter int DAC_MID        = 2048,
  parameter int DAC_MAX        = 4095,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 update,
  input  logic signed [biq_pkg::SAMPLE_W-1:0]  x0,
  input  biq_pkg::cfg_t                        cfg,
  output biq_pkg::out_t                        result
);
  import biq_pkg::*;

  localparam int PROD_W = COEF_W + SAMPLE_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam int DAC_W  = 18;
  localparam logic signed [ACC_W-1:0] ACC_HI  = ACC_W'(Q15_MAX);
  localparam logic signed [ACC_W-1:0] ACC_LO  = ACC_W'(Q15_MIN);
  localparam logic signed [DAC_W-1:0] DAC_MID_S = DAC_W'(DAC_MID);
  localparam logic signed [DAC_W-1:0] DAC_MAX_S = DAC_W'(DAC_MAX);

  logic signed [SAMPLE_W-1:0] hist_x1, hist_x2, hist_y1, hist_y2;
  logic signed [PROD_W-1:0]   p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    acc_sh;
  logic signed [SAMPLE_W-1:0] y0;
  logic signed [DAC_W-1:0]    dac_sum;
  logic        [CODE_W-1:0]   dac;

  // Products of coefficients and taps
  assign p_b0 = PROD_W'(cfg.coef_b0) * PROD_W'(x0);
  assign p_b1 = PROD_W'(cfg.coef_b1) * PROD_W'(hist_x1);
  assign p_b2 = PROD_W'(cfg.coef_b2) * PROD_W'(hist_x2);
  assign p_a1 = PROD_W'(cfg.coef_a1) * PROD_W'(hist_y1);
  assign p_a2 = PROD_W'(cfg.coef_a2) * PROD_W'(hist_y2);

  // Exact sum, then floor shift back to Q15
  assign acc    = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2) - ACC_W'(p_a1) - ACC_W'(p_a2);
  assign acc_sh = acc >>> COEF_FRAC_BITS;

  // Saturate the output, then form the DAC code
  always_comb begin
    if (acc_sh > ACC_HI) begin
      y0 = Q15_MAX;
    end else if (acc_sh < ACC_LO) begin
      y0 = Q15_MIN;
    end else begin
      y0 = acc_sh[SAMPLE_W-1:0];
    end
    dac_sum = DAC_W'(y0 >>> CODE_SHIFT) + DAC_MID_S;
    if (dac_sum < 0) begin
      dac = '0;
    end else if (dac_sum > DAC_MAX_S) begin
      dac = DAC_MAX_S[CODE_W-1:0];
    end else begin
      dac = dac_sum[CODE_W-1:0];
    end
    result.sample_out = y0;
    result.dac_code   = dac;
  end

  // Advance the delay line when a sample completes
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_x1 <= '0;
      hist_x2 <= '0;
      hist_y1 <= '0;
      hist_y2 <= '0;
    end else if (update) begin
      hist_x1 <= x0;
      hist_x2 <= hist_x1;
      hist_y1 <= y0;
      hist_y2 <= hist_y1;
    end
  end

endmodule

// File: rtl/biquad_iir_q28_adc_dac.sv
// Direct-form-I biquad with Q28 coefficients, converter-code input and DAC-code output.
// Takes one sample per clock unless the output stalls; a sample passes through the input
// register, then the result register. The sustained rate of one sample per cycle is set
// by the output feedback loop, where five 32x16 products, their sum, the rescale and the
// Q15 saturation all settle combinationally so that the next sample sees the updated
// history. With filter_enable low a transfer in yields no result and leaves the history
// untouched. The user must write coefficients only while idle; the block does not check.
module biquad_iir_q28_adc_dac #(
  parameter int ADC_MID        = 2048,
  parameter int DAC_MID        = 2048,
  parameter int DAC_MAX        = 4095,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  biq_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output biq_pkg::out_t                    out_data,
  input  logic                             cfg_wr_en,
  input  logic [biq_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [biq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import biq_pkg::*;

  cfg_t                       cfg;
  logic signed [SAMPLE_W-1:0] x0_in;
  logic signed [SAMPLE_W-1:0] s1_x0;
  logic                       s1_valid;
  logic                       advance;
  logic                       in_xfer;
  logic                       load;
  out_t                       core_out;

  biq_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  biq_front #(
    .ADC_MID (ADC_MID)
  ) u_front (
    .in_data  (in_data),
    .adc_path (cfg.adc_path),
    .x0       (x0_in)
  );

  biq_core #(
    .DAC_MID        (DAC_MID),
    .DAC_MAX        (DAC_MAX),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .update (s1_valid && advance),
    .x0     (s1_x0),
    .cfg    (cfg),
    .result (core_out)
  );

  // Handshake: result register frees when empty or being taken
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign in_xfer  = in_valid && !in_stall;
  assign load     = in_xfer && cfg.filter_enable;

  // Input register: drop transfers while disabled
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= load || (s1_valid && !advance);
    end
    if (load) begin
      s1_x0 <= x0_in;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
    if (advance && s1_valid) begin
      out_data <= core_out;
    end
  end

  // A full input register behind a stalled result must hold off the source
  a_hold_off: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && out_stall) |-> in_stall)
    else $error("input accepted while both stages are full");

  // A transfer while disabled must not create work
  a_drop_disabled: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !cfg.filter_enable) |=> !s1_valid)
    else $error("disabled transfer reached the input register");

  // A new result only appears from a filled input register
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result raised without a pending sample");

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the Q28 direct-form-I biquad with converter-code in and DAC code out.
module testbench;
  import biq_pkg::*;

  localparam int ADC_MID        = 2048;
  localparam int DAC_MID        = 2048;
  localparam int DAC_MAX        = 4095;
  localparam int COEF_FRAC_BITS = 28;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int RANDOM_ITEMS   = 1280;
  localparam int LONG_HOLD      = 80;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [CFG_DATA_W-1:0]  COEF_ONE   = 32'h1000_0000;
  localparam logic [CFG_DATA_W-1:0]  COEF_MAXV  = 32'h7FFF_FFFF;
  localparam logic [CFG_DATA_W-1:0]  COEF_MINV  = 32'h8000_0000;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_t                    in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_t                   out_data;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Items waiting to be offered and filtered samples still to arrive
  in_t  samples_to_send[$];
  out_t filtered_due[$];

  // Predictor copy of the configuration and the filter history
  int     cb0, cb1, cb2, ca1, ca2;
  bit     adc_sel, filt_on;
  longint hx1, hx2, hy1, hy2;

  int  mismatches   = 0;
  int  results_seen = 0;
  int  cycles       = 0;
  bit  in_taken     = 1'b0;

  biquad_iir_q28_adc_dac #(
    .ADC_MID(ADC_MID),
    .DAC_MID(DAC_MID),
    .DAC_MAX(DAC_MAX),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Work out the filtered sample for one transfer in and advance the history
  function automatic bit biquad_predict(input in_t item, output out_t res);
    longint x0, acc, y0, dac;
    res = '0;
    if (!filt_on) return 1'b0;
    if (adc_sel)
      x0 = clip((longint'(item.adc_code) - ADC_MID) * 16, longint'(Q15_MIN),
                longint'(Q15_MAX));
    else
      x0 = longint'($signed(item.sample_in));
    acc = longint'(cb0) * x0 + longint'(cb1) * hx1 + longint'(cb2) * hx2
        - longint'(ca1) * hy1 - longint'(ca2) * hy2;
    y0 = clip(acc >>> COEF_FRAC_BITS, longint'(Q15_MIN), longint'(Q15_MAX));
    hx2 = hx1;
    hx1 = x0;
    hy2 = hy1;
    hy1 = y0;
    dac = clip((y0 >>> CODE_SHIFT) + DAC_MID, 0, DAC_MAX);
    res.sample_out = y0[SAMPLE_W-1:0];
    res.dac_code   = dac[CODE_W-1:0];
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  // Monitor: track config writes, predict on each transfer in, check each transfer out
  always @(posedge clk) begin
    out_t want;
    out_t got;
    if (rst) begin
      cb0 = 0; cb1 = 0; cb2 = 0; ca1 = 0; ca2 = 0;
      adc_sel = 1'b1;
      filt_on = 1'b0;
      hx1 = 0; hx2 = 0; hy1 = 0; hy2 = 0;
      in_taken <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_COEF_B0:       cb0 = cfg_wdata;
          REG_COEF_B1:       cb1 = cfg_wdata;
          REG_COEF_B2:       cb2 = cfg_wdata;
          REG_COEF_A1:       ca1 = cfg_wdata;
          REG_COEF_A2:       ca2 = cfg_wdata;
          REG_ADC_PATH:      adc_sel = cfg_wdata[0];
          REG_FILTER_ENABLE: filt_on = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        results_seen++;
        if (filtered_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected result sample_out=%0d dac_code=%0d",
                                  got.sample_out, got.dac_code));
        end else begin
          want = filtered_due.pop_front();
          if (got.sample_out !== want.sample_out)
            flag_mismatch($sformatf("sample_out expected %0d got %0d",
                                    want.sample_out, got.sample_out));
          if (got.dac_code !== want.dac_code)
            flag_mismatch($sformatf("dac_code expected %0d got %0d",
                                    want.dac_code, got.dac_code));
        end
      end
      if (in_valid && !in_stall) begin
        if (biquad_predict(in_data, want)) filtered_due.push_back(want);
      end
      in_taken <= in_valid && !in_stall;
    end
  end

  // Sender: bursts of random length separated by random gaps, hold until transfer
  int burst_left = 1;
  int gap_left   = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the stalled item
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (samples_to_send.size() > 0) begin
      in_data  <= samples_to_send.pop_front();
      in_valid <= 1'b1;
      if (burst_left > 1) begin
        burst_left <= burst_left - 1;
      end else begin
        burst_left <= $urandom_range(1, 24);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: stall pattern changes mode now and then, with occasional long hold-offs
  int stall_mode    = 0;
  int mode_left     = 0;
  int hold_left     = 0;
  int next_hold_at  = 150;
  bit stall_phase   = 1'b0;
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (results_seen >= next_hold_at) begin
      out_stall    <= 1'b1;
      hold_left    <= LONG_HOLD;
      next_hold_at <= next_hold_at + 500;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(10, 60);
      end else begin
        mode_left <= mode_left - 1;
      end
      stall_phase <= !stall_phase;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= 1'($urandom_range(0, 1));
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= stall_phase;
      endcase
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("biquad_iir_q28_adc_dac regression: fail");
      $finish;
    end
  end

  task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic end_writes;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Flag register value with random upper bits that the block must drop
  function automatic logic [CFG_DATA_W-1:0] flag_val(input bit b);
    return ($urandom & ~32'd1) | b;
  endfunction

  task automatic push_sample(input logic [CODE_W-1:0] code, input logic [SAMPLE_W-1:0] s);
    in_t item;
    item.adc_code  = code;
    item.sample_in = s;
    samples_to_send.push_back(item);
  endtask

  // Wait until everything sent has come back, then let the pipeline empty
  task automatic wait_quiet;
    while (samples_to_send.size() != 0 || in_valid || filtered_due.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_coef(input int style);
    int lim;
    case (style)
      0: begin
        case ($urandom_range(0, 4))
          0:       return COEF_MINV;
          1:       return COEF_MAXV;
          2:       return '0;
          3:       return COEF_ONE;
          default: return -COEF_ONE;
        endcase
      end
      1:       return $urandom;
      default: begin
        lim = 1 << 28;
        return int'($urandom_range(0, 2 * lim)) - lim;
      end
    endcase
  endfunction

  initial begin
    int active_items;
    int n;
    int style;
    int sig_mode;
    int a2v;
    int lim;
    int b0v;
    longint walk;
    bit on;
    bit path;
    logic [SAMPLE_W-1:0] s;

    active_items = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Disabled out of reset: items give nothing
    push_sample(12'hFFF, 16'h8000);
    push_sample(12'h000, 16'h7FFF);
    wait_quiet;

    // Unity pass-through on the converter path: code extremes
    set_reg(REG_COEF_B0, COEF_ONE);
    set_reg(REG_COEF_B1, '0);
    set_reg(REG_COEF_B2, '0);
    set_reg(REG_COEF_A1, '0);
    set_reg(REG_COEF_A2, '0);
    set_reg(REG_ADC_PATH, 32'd1);
    set_reg(REG_FILTER_ENABLE, 32'd1);
    end_writes;
    push_sample(12'h000, SAMPLE_W'($urandom));
    push_sample(12'hFFF, SAMPLE_W'($urandom));
    push_sample(12'h800, SAMPLE_W'($urandom));
    push_sample(12'h7FF, SAMPLE_W'($urandom));
    push_sample(12'hAAA, SAMPLE_W'($urandom));
    push_sample(12'h555, SAMPLE_W'($urandom));
    wait_quiet;

    // Extreme coefficients on the Q15 path; saturation both ways, stray index dropped
    set_reg(REG_COEF_B0, COEF_MAXV);
    set_reg(REG_COEF_B1, COEF_MINV);
    set_reg(REG_COEF_B2, COEF_MAXV);
    set_reg(REG_COEF_A1, COEF_MINV);
    set_reg(REG_COEF_A2, COEF_MAXV);
    set_reg(REG_ADC_PATH, 32'hFFFF_FFFE);
    set_reg(REG_UNUSED, 32'hFFFF_FFFF);
    end_writes;
    push_sample(CODE_W'($urandom), 16'h7FFF);
    push_sample(CODE_W'($urandom), 16'h8000);
    push_sample(CODE_W'($urandom), 16'h0000);
    push_sample(CODE_W'($urandom), 16'hFFFF);
    push_sample(CODE_W'($urandom), 16'h0001);
    push_sample(CODE_W'($urandom), 16'h5555);
    push_sample(CODE_W'($urandom), 16'hAAAA);
    wait_quiet;

    // Disable with a wide value: items ignored, history held for the re-enable
    set_reg(REG_FILTER_ENABLE, 32'hFFFF_FFFE);
    end_writes;
    push_sample(12'hFFF, 16'h7FFF);
    push_sample(12'h000, 16'h8000);
    push_sample(12'h123, 16'h1234);
    wait_quiet;
    set_reg(REG_COEF_B0, COEF_ONE);
    set_reg(REG_COEF_B1, COEF_ONE);
    set_reg(REG_COEF_B2, COEF_ONE);
    set_reg(REG_COEF_A1, '0);
    set_reg(REG_COEF_A2, '0);
    set_reg(REG_FILTER_ENABLE, 32'd1);
    end_writes;
    push_sample(CODE_W'($urandom), 16'h1000);
    push_sample(CODE_W'($urandom), 16'hF000);
    push_sample(CODE_W'($urandom), 16'h7FFF);
    push_sample(CODE_W'($urandom), 16'h7FFF);
    wait_quiet;

    // Random phases: new settings each time, half with stable filters, on random or smooth signals
    walk = 0;
    while (active_items < RANDOM_ITEMS) begin
      wait_quiet;
      style = $urandom_range(0, 9);
      if (style < 5) begin
        a2v = int'($urandom_range(0, 440000000)) - 200000000;
        lim = (268435456 + a2v) / 10 * 9;
        b0v = int'($urandom_range(0, 1 << 27)) - (1 << 26);
        set_reg(REG_COEF_B0, b0v);
        set_reg(REG_COEF_B1, b0v * 2);
        set_reg(REG_COEF_B2, pick_coef(2) >>> 2);
        set_reg(REG_COEF_A1, int'($urandom_range(0, 2 * lim)) - lim);
        set_reg(REG_COEF_A2, a2v);
      end else begin
        set_reg(REG_COEF_B0, pick_coef(style < 8 ? 1 : 0));
        set_reg(REG_COEF_B1, pick_coef(style < 8 ? 2 : 0));
        set_reg(REG_COEF_B2, pick_coef(style < 7 ? 1 : 0));
        set_reg(REG_COEF_A1, pick_coef(style < 8 ? 2 : 0));
        set_reg(REG_COEF_A2, pick_coef(style < 7 ? 1 : 0));
      end
      path = 1'($urandom_range(0, 1));
      on   = ($urandom_range(0, 7) != 0);
      set_reg(REG_ADC_PATH, flag_val(path));
      if ($urandom_range(0, 3) == 0) set_reg(REG_UNUSED, $urandom);
      set_reg(REG_FILTER_ENABLE, flag_val(on));
      end_writes;

      n = on ? $urandom_range(40, 140) : $urandom_range(5, 15);
      sig_mode = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
        case (sig_mode)
          0: push_sample(CODE_W'($urandom), SAMPLE_W'($urandom));
          1: begin
            s = SAMPLE_W'(int'($urandom_range(0, 4000)) - 2000);
            push_sample(CODE_W'(ADC_MID + int'($urandom_range(0, 400)) - 200), s);
          end
          default: begin
            walk = clip(walk + int'($urandom_range(0, 4000)) - 2000, longint'(Q15_MIN),
                        longint'(Q15_MAX));
            s = SAMPLE_W'(walk);
            push_sample(CODE_W'((walk >>> CODE_SHIFT) + ADC_MID), s);
          end
        endcase
      end
      if (on) active_items += n;
    end

    wait_quiet;
    if (mismatches == 0 && filtered_due.size() == 0) begin
      $display("biquad_iir_q28_adc_dac regression: pass");
    end else begin
      $display("biquad_iir_q28_adc_dac regression: fail");
    end
    $finish;
  end

endmodule
